// File: src/assert_macros.svh
// Assertion macros for the RTL, included by magic_frame_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property, disabled while reset is asserted.
`define MFC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication with an overlapping consequent.
`define MFC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Clocked implication with the consequent in the next cycle.
`define MFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define MFC_ASSERT(lbl, clk, rst_n, prop, msg)
`define MFC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define MFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: src/mfc_pkg.sv
// Types, constants and the checksum step of the magic frame checker.
package mfc_pkg;

  localparam logic [7:0]  MagicFirst     = 8'h73;  // 's'
  localparam logic [7:0]  MagicSecond    = 8'h4D;  // 'M'
  localparam logic [15:0] MinFrameLength = 16'd10;
  localparam logic [15:0] ResetMaxLength = 16'd3000;
  localparam logic [15:0] ChecksumBytes  = 16'd2;

  typedef enum logic [1:0] {
    KIND_PAYLOAD    = 2'd0,
    KIND_GOOD       = 2'd1,
    KIND_BAD_CHECK  = 2'd2,
    KIND_LEN_REJECT = 2'd3
  } result_kind_t;

  typedef enum logic [10:0] {
    PH_HUNT_S  = 11'b000_0000_0001,
    PH_HUNT_M  = 11'b000_0000_0010,
    PH_LEN_LO  = 11'b000_0000_0100,
    PH_LEN_HI  = 11'b000_0000_1000,
    PH_TYPE_LO = 11'b000_0001_0000,
    PH_TYPE_HI = 11'b000_0010_0000,
    PH_SEQ_LO  = 11'b000_0100_0000,
    PH_SEQ_HI  = 11'b000_1000_0000,
    PH_PAYLOAD = 11'b001_0000_0000,
    PH_CHK_LO  = 11'b010_0000_0000,
    PH_CHK_HI  = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    result_kind_t kind;
    logic [7:0]   payload_byte;
    logic [15:0]  frame_type;
    logic [15:0]  frame_sequence;
    logic [15:0]  frame_total_length;
    logic         end_of_frame;
  } result_t;

  typedef struct packed {
    logic [7:0] sum_high;
    logic [7:0] sum_low;
  } checksum_t;

  // One checksum step: low is a byte sum, high shifts in the carry and xors the byte.
  function automatic checksum_t mfc_accumulate(checksum_t cur, logic [7:0] b);
    logic [8:0] j;
    checksum_t  res;
    j            = {1'b0, cur.sum_low} + {1'b0, b};
    res.sum_low  = j[7:0];
    res.sum_high = {cur.sum_high[6:0], j[8]} ^ b;
    return res;
  endfunction

endpackage

// File: src/mfc_in_if.sv
// Byte input channel: valid/ready handshake with one data byte.
interface mfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// File: src/mfc_out_if.sv
// Result channel: valid/ready handshake with the frame result fields.
interface mfc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] frame_type;
  logic [15:0] frame_sequence;
  logic [15:0] frame_total_length;
  logic        end_of_frame;

  modport source (
    output valid, output result_kind, output payload_byte, output frame_type,
    output frame_sequence, output frame_total_length, output end_of_frame,
    input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input frame_type,
    input frame_sequence, input frame_total_length, input end_of_frame,
    output ready
  );
endinterface

// File: src/magic_frame_checker.sv
// Top level of the magic frame checker: input stage, parser and result register.
//
// Byte-serial frame checker. Each input transaction on in_ch carries one byte
// of the received stream. The block hunts for the magic pair 's','M', takes a
// little-endian length, type and sequence, passes payload bytes out one per
// transaction and closes each frame with a good / checksum-mismatch result.
// Lengths above max_frame_length or below 10 give a length-rejected result
// right after the length's high byte.
// Header and first checksum bytes give no output transaction.
// Pipeline: input register -> parser logic -> result register.
// A byte accepted on in_ch is held in the input register, then its result is registered in the result register.
// Throughput: one byte per cycle, sustained, while out_ch keeps up.
// When out_ch stalls, the result register holds; the input stage still takes
// one more byte, then in_ch.ready drops until the result is taken.
// cfg_we/cfg_wdata write max_frame_length; write only while idle.
// Reset (rst_n, synchronous) empties both stages, returns the parser to
// hunting the first magic byte and sets max_frame_length to 3000.
module magic_frame_checker
  import mfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  mfc_in_if.sink       in_ch,
  mfc_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);

`include "assert_macros.svh"

  // configuration
  logic [15:0] max_len_r;

  // input stage
  logic        stage_v_r, stage_v_nxt;
  logic [7:0]  stage_byte_r;

  // result register
  logic        out_v_r, out_v_nxt;
  result_t     out_r;

  logic        out_free;   // result register can take a new value this cycle
  logic        advance;    // the staged byte is processed this cycle
  logic        in_accept;
  logic        res_valid;
  result_t     res;

  assign out_free    = !out_v_r || out_ch.ready;
  assign advance     = stage_v_r && out_free;
  assign in_ch.ready = !stage_v_r || out_free;
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= ResetMaxLength;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  always_comb begin
    stage_v_nxt = stage_v_r;
    if (in_accept) begin
      stage_v_nxt = 1'b1;
    end else if (advance) begin
      stage_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_byte_r <= in_ch.data_byte;
    end
  end

  mfc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (stage_byte_r),
    .max_len   (max_len_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // A processed byte with no result still frees the slot if it was taken.
  always_comb begin
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = res_valid;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid              = out_v_r;
  assign out_ch.result_kind        = out_r.kind;
  assign out_ch.payload_byte       = out_r.payload_byte;
  assign out_ch.frame_type         = out_r.frame_type;
  assign out_ch.frame_sequence     = out_r.frame_sequence;
  assign out_ch.frame_total_length = out_r.frame_total_length;
  assign out_ch.end_of_frame       = out_r.end_of_frame;

  // staged byte must not be overwritten before it is processed
  `MFC_ASSERT_NEXT(a_stage_hold, clk, rst_n, stage_v_r && !advance, stage_v_r && $stable(stage_byte_r), "staged byte lost")

  // a stalled result stays put
  `MFC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_v_r && !out_ch.ready, out_v_r && $stable(out_r), "stalled result changed")

  // frame end flag goes with every kind but payload
  `MFC_ASSERT_IMPL(a_eof_kind, clk, rst_n, out_v_r, out_r.end_of_frame == (out_r.kind != KIND_PAYLOAD), "end_of_frame does not match kind")

  // a fresh payload result carries the byte that was just processed
  `MFC_ASSERT_IMPL(a_payload_byte, clk, rst_n, $past(advance) && out_v_r && out_r.kind == KIND_PAYLOAD, out_r.payload_byte == $past(stage_byte_r), "payload byte mismatch")

endmodule

// File: src/mfc_parser.sv
// Frame parser: phase machine, header fields and running checksum.
module mfc_parser
  import mfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,        // consume data_byte this cycle
  input  logic [7:0]  data_byte,
  input  logic [15:0] max_len,
  output logic        res_valid,
  output result_t     res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] type_r, type_nxt;
  logic [15:0] seq_r, seq_nxt;
  checksum_t   sum_r, sum_nxt;
  logic [7:0]  chk_low_r, chk_low_nxt;

  checksum_t   sum_acc;
  checksum_t   sum_start;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic        good;

  assign sum_acc   = mfc_accumulate(sum_r, data_byte);
  assign sum_start = mfc_accumulate(16'h0000, data_byte);
  assign len_full  = {data_byte, length_r[7:0]};
  assign count_inc = byte_count_r + 16'd1;
  assign good      = (chk_low_r == sum_r.sum_low) && (data_byte == sum_r.sum_high);

  always_comb begin
    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    length_nxt     = length_r;
    type_nxt       = type_r;
    seq_nxt        = seq_r;
    sum_nxt        = sum_r;
    chk_low_nxt    = chk_low_r;
    res_valid      = 1'b0;
    res.kind               = KIND_PAYLOAD;
    res.payload_byte       = 8'h00;
    res.frame_type         = type_r;
    res.frame_sequence     = seq_r;
    res.frame_total_length = length_r;
    res.end_of_frame       = 1'b0;

    if (step) begin
      unique case (phase_r)
        PH_HUNT_S, PH_HUNT_M: begin
          if (data_byte == MagicFirst) begin
            // new frame starts here, also on a repeated 's'
            sum_nxt        = sum_start;
            length_nxt     = 16'h0000;
            type_nxt       = 16'h0000;
            seq_nxt        = 16'h0000;
            chk_low_nxt    = 8'h00;
            byte_count_nxt = 16'd1;
            phase_nxt      = PH_HUNT_M;
          end else if (phase_r == PH_HUNT_M && data_byte == MagicSecond) begin
            sum_nxt        = sum_acc;
            byte_count_nxt = 16'd2;
            phase_nxt      = PH_LEN_LO;
          end else begin
            phase_nxt = PH_HUNT_S;
          end
        end
        PH_LEN_LO: begin
          sum_nxt        = sum_acc;
          length_nxt     = {8'h00, data_byte};
          byte_count_nxt = 16'd3;
          phase_nxt      = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          sum_nxt        = sum_acc;
          length_nxt     = len_full;
          byte_count_nxt = 16'd4;
          if (len_full > max_len || len_full < MinFrameLength) begin
            res_valid              = 1'b1;
            res.kind               = KIND_LEN_REJECT;
            res.frame_total_length = len_full;
            res.end_of_frame       = 1'b1;
            phase_nxt              = PH_HUNT_S;
          end else begin
            phase_nxt = PH_TYPE_LO;
          end
        end
        PH_TYPE_LO: begin
          sum_nxt        = sum_acc;
          type_nxt       = {8'h00, data_byte};
          byte_count_nxt = 16'd5;
          phase_nxt      = PH_TYPE_HI;
        end
        PH_TYPE_HI: begin
          sum_nxt        = sum_acc;
          type_nxt       = {data_byte, type_r[7:0]};
          byte_count_nxt = 16'd6;
          phase_nxt      = PH_SEQ_LO;
        end
        PH_SEQ_LO: begin
          sum_nxt        = sum_acc;
          seq_nxt        = {8'h00, data_byte};
          byte_count_nxt = 16'd7;
          phase_nxt      = PH_SEQ_HI;
        end
        PH_SEQ_HI: begin
          sum_nxt        = sum_acc;
          seq_nxt        = {data_byte, seq_r[7:0]};
          byte_count_nxt = 16'd8;
          phase_nxt      = (length_r == MinFrameLength) ? PH_CHK_LO : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum_nxt          = sum_acc;
          byte_count_nxt   = count_inc;
          res_valid        = 1'b1;
          res.payload_byte = data_byte;
          if (count_inc >= length_r - ChecksumBytes) begin
            phase_nxt = PH_CHK_LO;
          end
        end
        PH_CHK_LO: begin
          chk_low_nxt    = data_byte;
          byte_count_nxt = count_inc;
          phase_nxt      = PH_CHK_HI;
        end
        PH_CHK_HI: begin
          byte_count_nxt   = count_inc;
          res_valid        = 1'b1;
          res.kind         = good ? KIND_GOOD : KIND_BAD_CHECK;
          res.end_of_frame = 1'b1;
          phase_nxt        = PH_HUNT_S;
        end
        default: begin
          phase_nxt = PH_HUNT_S;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT_S;
      byte_count_r <= 16'h0000;
      length_r     <= 16'h0000;
      type_r       <= 16'h0000;
      seq_r        <= 16'h0000;
      sum_r        <= 16'h0000;
      chk_low_r    <= 8'h00;
    end else begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      length_r     <= length_nxt;
      type_r       <= type_nxt;
      seq_r        <= seq_nxt;
      sum_r        <= sum_nxt;
      chk_low_r    <= chk_low_nxt;
    end
  end

endmodule
